[rtl/kvt_pkg.sv]
// Shared types, constants and helpers for the key-value table with expiry.
// Used by every module of the block but kvt_ram; depends on nothing.
package kvt_pkg;

    localparam int KEY_W       = 64;
    localparam int VAL_W       = 64;
    localparam int LEN_W       = 4;
    localparam int TIME_W      = 32;
    localparam int MODE_W      = 2;
    localparam int STAMP_W     = 64;
    localparam int CFG_MAX_W   = 7;
    localparam int OUT_CNT_W   = 7;
    localparam int APB_ADDR_W  = 3;
    localparam int APB_DATA_W  = 32;
    localparam int TABLE_ENTRIES_DEF = 64;

    localparam logic [LEN_W-1:0] KEY_BYTES   = 4'd8;
    localparam logic [LEN_W-1:0] VALUE_BYTES = 4'd8;

    localparam logic [MODE_W-1:0] MODE_ADD    = 2'd0;
    localparam logic [MODE_W-1:0] MODE_LOOKUP = 2'd1;
    localparam logic [MODE_W-1:0] MODE_SWEEP  = 2'd2;

    // register index, taken from paddr[2]
    localparam logic REG_TTL = 1'b0;
    localparam logic REG_MAX = 1'b1;

    typedef enum logic [2:0] {
        OP_ADD,
        OP_LOOKUP,
        OP_SWEEP,
        OP_REJECT,
        OP_NOP
    } op_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_CHECK,
        ST_FINISH
    } eng_state_t;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [KEY_W-1:0]  key;
        logic [LEN_W-1:0]  key_length;
        logic [VAL_W-1:0]  value;
        logic [LEN_W-1:0]  value_length;
        logic [TIME_W-1:0] now;
    } kvt_in_t;

    typedef struct packed {
        logic                 status;
        logic                 hit;
        logic [VAL_W-1:0]     value_out;
        logic [LEN_W-1:0]     value_length_out;
        logic [OUT_CNT_W-1:0] removed_count;
        logic [OUT_CNT_W-1:0] entries_in_use;
    } kvt_out_t;

    // classified request as it sits in the queue
    typedef struct packed {
        op_t               op;
        logic [KEY_W-1:0]  key;
        logic [KEY_W-1:0]  key_mask;
        logic [LEN_W-1:0]  key_length;
        logic [VAL_W-1:0]  value;
        logic [LEN_W-1:0]  value_length;
        logic [TIME_W-1:0] now;
    } kvt_req_t;

    // one table entry as stored in the RAM
    typedef struct packed {
        logic [KEY_W-1:0]   key;
        logic [LEN_W-1:0]   key_length;
        logic [VAL_W-1:0]   value;
        logic [LEN_W-1:0]   value_length;
        logic [TIME_W-1:0]  expiry;
        logic [STAMP_W-1:0] stamp;
    } kvt_rec_t;

    // ones over the low n bytes; n of 8 or more gives all ones
    function automatic logic [KEY_W-1:0] byte_mask(input logic [LEN_W-1:0] n);
        logic [KEY_W-1:0] m;
        m = '0;
        for (int b = 0; b < KEY_W / 8; b++) begin
            m[8*b +: 8] = (LEN_W'(b) < n) ? 8'hFF : 8'h00;
        end
        return m;
    endfunction

endpackage

[rtl/kvt_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// Stand-alone; no package dependency.
module kvt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[rtl/kvt_front.sv]
// Front end: accepts requests, classifies them and holds them in a two-entry queue.
// Depends on kvt_pkg.
module kvt_front (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  kvt_pkg::kvt_in_t  s_data,
    output logic              q_valid,
    output kvt_pkg::kvt_req_t q_req,
    input  logic              q_pop
);

    kvt_pkg::kvt_req_t           q_mem_reg [2];
    logic                        wr_ptr_reg, wr_ptr_next;
    logic                        rd_ptr_reg, rd_ptr_next;
    logic [1:0]                  cnt_reg, cnt_next;
    kvt_pkg::kvt_req_t           cls;
    logic [kvt_pkg::LEN_W-1:0]   vlen_sat;
    logic                        push;

    always_comb begin
        vlen_sat = (s_data.value_length > kvt_pkg::VALUE_BYTES) ?
                   kvt_pkg::VALUE_BYTES : s_data.value_length;
        cls.key_mask     = kvt_pkg::byte_mask(s_data.key_length);
        cls.key          = s_data.key & cls.key_mask;
        cls.key_length   = s_data.key_length;
        cls.value        = s_data.value & kvt_pkg::byte_mask(vlen_sat);
        cls.value_length = vlen_sat;
        cls.now          = s_data.now;
        case (s_data.mode)
            kvt_pkg::MODE_ADD: begin
                cls.op = (s_data.key_length > kvt_pkg::KEY_BYTES) ?
                         kvt_pkg::OP_REJECT : kvt_pkg::OP_ADD;
            end
            kvt_pkg::MODE_LOOKUP: begin
                cls.op = (s_data.key_length > kvt_pkg::KEY_BYTES) ?
                         kvt_pkg::OP_REJECT : kvt_pkg::OP_LOOKUP;
            end
            kvt_pkg::MODE_SWEEP: begin
                cls.op = kvt_pkg::OP_SWEEP;
            end
            default: begin
                cls.op = kvt_pkg::OP_NOP;
            end
        endcase
    end

    assign s_ready = (cnt_reg != 2'd2);
    assign push    = s_valid && s_ready;
    assign q_valid = (cnt_reg != 2'd0);
    assign q_req   = q_mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = q_pop ? ~rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + 2'(push) - 2'(q_pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            q_mem_reg[wr_ptr_reg] <= cls;
        end
    end

endmodule

[rtl/kvt_engine.sv]
// Back end: walks the entry RAM to match, insert, refresh and expire; owns the result register.
// Depends on kvt_pkg and kvt_ram.
module kvt_engine #(
    parameter int TABLE_ENTRIES = kvt_pkg::TABLE_ENTRIES_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            q_valid,
    input  kvt_pkg::kvt_req_t               q_req,
    output logic                            q_pop,
    input  logic [kvt_pkg::TIME_W-1:0]      ttl,
    input  logic [kvt_pkg::CFG_MAX_W-1:0]   max_entries,
    output logic                            m_valid,
    input  logic                            m_ready,
    output kvt_pkg::kvt_out_t               m_data
);

    localparam int IW   = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CW0  = $clog2(TABLE_ENTRIES + 1);
    localparam int CW   = (CW0 > kvt_pkg::OUT_CNT_W) ? CW0 : kvt_pkg::OUT_CNT_W;
    localparam int RECW = $bits(kvt_pkg::kvt_rec_t);
    localparam logic [IW:0]   N_IDX = (IW+1)'(TABLE_ENTRIES);
    localparam logic [CW-1:0] N_CNT = CW'(TABLE_ENTRIES);

    kvt_pkg::eng_state_t           state_reg, state_next;
    kvt_pkg::kvt_req_t             req_reg, req_next;
    logic [IW:0]                   idx_reg, idx_next;
    logic                          found_reg, found_next;
    logic [IW-1:0]                 fidx_reg, fidx_next;
    kvt_pkg::kvt_rec_t             frec_reg, frec_next;
    logic                          free_found_reg, free_found_next;
    logic [IW-1:0]                 free_idx_reg, free_idx_next;
    logic [CW-1:0]                 removed_reg, removed_next;
    logic [CW-1:0]                 live_reg, live_next;
    logic [kvt_pkg::STAMP_W-1:0]   stamp_reg, stamp_next;
    logic [TABLE_ENTRIES-1:0]      valid_reg, valid_next;
    logic                          out_valid_reg, out_valid_next;
    kvt_pkg::kvt_out_t             out_reg, out_next;

    logic                          ram_we, ram_re;
    logic [IW-1:0]                 ram_waddr;
    kvt_pkg::kvt_rec_t             ram_wrec;
    logic [RECW-1:0]               ram_rdata;
    kvt_pkg::kvt_rec_t             rec_rd;
    logic [CW-1:0]                 max_ext, limit;
    logic                          out_free, key_match;
    kvt_pkg::kvt_out_t             res;

    kvt_ram #(
        .WIDTH (RECW),
        .DEPTH (TABLE_ENTRIES)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wrec),
        .re    (ram_re),
        .raddr (idx_reg[IW-1:0]),
        .rdata (ram_rdata)
    );

    assign rec_rd    = ram_rdata;
    assign max_ext   = CW'(max_entries);
    assign limit     = (max_ext < N_CNT) ? max_ext : N_CNT;
    assign out_free  = !out_valid_reg || m_ready;
    assign key_match = ((rec_rd.key ^ req_reg.key) & req_reg.key_mask) == '0;
    assign m_valid   = out_valid_reg;
    assign m_data    = out_reg;

    always_comb begin
        state_next      = state_reg;
        req_next        = req_reg;
        idx_next        = idx_reg;
        found_next      = found_reg;
        fidx_next       = fidx_reg;
        frec_next       = frec_reg;
        free_found_next = free_found_reg;
        free_idx_next   = free_idx_reg;
        removed_next    = removed_reg;
        live_next       = live_reg;
        stamp_next      = stamp_reg;
        valid_next      = valid_reg;
        out_valid_next  = (out_valid_reg && m_ready) ? 1'b0 : out_valid_reg;
        out_next        = out_reg;
        q_pop           = 1'b0;
        ram_we          = 1'b0;
        ram_re          = 1'b0;
        ram_waddr       = fidx_reg;
        ram_wrec        = frec_reg;
        res             = '0;

        case (state_reg)
            kvt_pkg::ST_IDLE: begin
                if (q_valid) begin
                    q_pop           = 1'b1;
                    req_next        = q_req;
                    idx_next        = '0;
                    found_next      = 1'b0;
                    free_found_next = 1'b0;
                    removed_next    = '0;
                    if (q_req.op == kvt_pkg::OP_ADD || q_req.op == kvt_pkg::OP_LOOKUP ||
                        q_req.op == kvt_pkg::OP_SWEEP) begin
                        state_next = kvt_pkg::ST_READ;
                    end else begin
                        state_next = kvt_pkg::ST_FINISH;
                    end
                end
            end
            kvt_pkg::ST_READ: begin
                if (idx_reg == N_IDX) begin
                    state_next = kvt_pkg::ST_FINISH;
                end else if (!valid_reg[idx_reg[IW-1:0]]) begin
                    if (!free_found_reg) begin
                        free_found_next = 1'b1;
                        free_idx_next   = idx_reg[IW-1:0];
                    end
                    idx_next = idx_reg + 1'b1;
                end else begin
                    ram_re     = 1'b1;
                    state_next = kvt_pkg::ST_CHECK;
                end
            end
            kvt_pkg::ST_CHECK: begin
                if (req_reg.op == kvt_pkg::OP_SWEEP) begin
                    if (!found_reg || rec_rd.stamp < frec_reg.stamp) begin
                        found_next = 1'b1;
                        fidx_next  = idx_reg[IW-1:0];
                        frec_next  = rec_rd;
                    end
                    idx_next   = idx_reg + 1'b1;
                    state_next = kvt_pkg::ST_READ;
                end else if (key_match) begin
                    found_next = 1'b1;
                    fidx_next  = idx_reg[IW-1:0];
                    frec_next  = rec_rd;
                    state_next = kvt_pkg::ST_FINISH;
                end else begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = kvt_pkg::ST_READ;
                end
            end
            kvt_pkg::ST_FINISH: begin
                if (req_reg.op == kvt_pkg::OP_SWEEP && found_reg &&
                    frec_reg.expiry <= req_reg.now) begin
                    // drop the oldest entry and rescan for the next oldest
                    valid_next[fidx_reg] = 1'b0;
                    live_next    = (live_reg != '0) ? live_reg - 1'b1 : live_reg;
                    removed_next = removed_reg + 1'b1;
                    idx_next     = '0;
                    found_next   = 1'b0;
                    state_next   = kvt_pkg::ST_READ;
                end else if (out_free) begin
                    case (req_reg.op)
                        kvt_pkg::OP_ADD: begin
                            if (found_reg) begin
                                ram_we              = 1'b1;
                                ram_waddr           = fidx_reg;
                                ram_wrec            = frec_reg;
                                ram_wrec.key_length = req_reg.key_length;
                                ram_wrec.expiry     = req_reg.now + ttl;
                                ram_wrec.stamp      = stamp_reg;
                                stamp_next          = stamp_reg + 1'b1;
                            end else if (live_reg >= limit || !free_found_reg) begin
                                res.status = 1'b1;
                            end else begin
                                ram_we                  = 1'b1;
                                ram_waddr               = free_idx_reg;
                                ram_wrec.key            = req_reg.key;
                                ram_wrec.key_length     = req_reg.key_length;
                                ram_wrec.value          = req_reg.value;
                                ram_wrec.value_length   = req_reg.value_length;
                                ram_wrec.expiry         = req_reg.now + ttl;
                                ram_wrec.stamp          = stamp_reg;
                                stamp_next              = stamp_reg + 1'b1;
                                valid_next[free_idx_reg] = 1'b1;
                                live_next               = live_reg + 1'b1;
                            end
                        end
                        kvt_pkg::OP_LOOKUP: begin
                            if (found_reg) begin
                                res.hit              = 1'b1;
                                res.value_out        = frec_reg.value;
                                res.value_length_out = frec_reg.value_length;
                            end
                        end
                        kvt_pkg::OP_SWEEP: begin
                            res.removed_count = removed_reg[kvt_pkg::OUT_CNT_W-1:0];
                        end
                        kvt_pkg::OP_REJECT: begin
                            res.status = 1'b1;
                        end
                        default: begin
                        end
                    endcase
                    res.entries_in_use = live_next[kvt_pkg::OUT_CNT_W-1:0];
                    out_next       = res;
                    out_valid_next = 1'b1;
                    state_next     = kvt_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = kvt_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= kvt_pkg::ST_IDLE;
            idx_reg        <= '0;
            found_reg      <= 1'b0;
            free_found_reg <= 1'b0;
            removed_reg    <= '0;
            live_reg       <= '0;
            stamp_reg      <= '0;
            valid_reg      <= '0;
            out_valid_reg  <= 1'b0;
        end else begin
            state_reg      <= state_next;
            idx_reg        <= idx_next;
            found_reg      <= found_next;
            free_found_reg <= free_found_next;
            removed_reg    <= removed_next;
            live_reg       <= live_next;
            stamp_reg      <= stamp_next;
            valid_reg      <= valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        req_reg      <= req_next;
        fidx_reg     <= fidx_next;
        frec_reg     <= frec_next;
        free_idx_reg <= free_idx_next;
        out_reg      <= out_next;
    end

endmodule

[rtl/key_value_table_with_expiry_core.sv]
// Top level of the key-value table with expiry: APB registers, front queue and engine.
// Depends on kvt_pkg, kvt_front and kvt_engine.
//
//  channel  | ports                          | moves
//  ---------+--------------------------------+--------------------------------
//  request  | s_valid, s_ready, s_data       | one kvt_in_t request per accept
//  result   | m_valid, m_ready, m_data       | one kvt_out_t result per request
//  config   | psel, penable, pwrite, paddr,  | ttl_seconds at 0x0,
//           | pwdata, prdata, pready         | max_entries at 0x4
//
// Add and lookup scan the entry RAM from slot 0; a free slot is stepped over in ST_READ
// and an occupied slot takes a registered RAM read, then a key compare, stopping at the
// first match. A sweep runs one full scan per removed entry plus one final scan; each
// scan ends with an end check and finish, and each removal leaves one fewer occupied slot.
// Reset clears all valid bits at once; no clearing pass is needed.
// A two-entry queue takes requests while the engine works; a full result register
// holds the engine until m_ready frees it.
module key_value_table_with_expiry_core #(
    parameter int TABLE_ENTRIES = kvt_pkg::TABLE_ENTRIES_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  kvt_pkg::kvt_in_t                  s_data,
    output logic                              m_valid,
    input  logic                              m_ready,
    output kvt_pkg::kvt_out_t                 m_data,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [kvt_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [kvt_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [kvt_pkg::APB_DATA_W-1:0]    prdata,
    output logic                              pready
);

    logic [kvt_pkg::TIME_W-1:0]     ttl_reg;
    logic [kvt_pkg::CFG_MAX_W-1:0]  max_reg;
    logic                           cfg_wr;
    logic                           q_valid, q_pop;
    kvt_pkg::kvt_req_t              q_req;

    // Register port: zero wait states, write in the access phase.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ttl_reg <= '0;
            max_reg <= '0;
        end else if (cfg_wr) begin
            case (paddr[2])
                kvt_pkg::REG_TTL: ttl_reg <= pwdata[kvt_pkg::TIME_W-1:0];
                kvt_pkg::REG_MAX: max_reg <= pwdata[kvt_pkg::CFG_MAX_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            kvt_pkg::REG_TTL: prdata = ttl_reg;
            kvt_pkg::REG_MAX: prdata = {{(kvt_pkg::APB_DATA_W-kvt_pkg::CFG_MAX_W){1'b0}}, max_reg};
            default:          prdata = '0;
        endcase
    end

    // Classify and queue requests.
    kvt_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .q_valid (q_valid),
        .q_req   (q_req),
        .q_pop   (q_pop)
    );

    // Carry out requests against the table and deliver results.
    kvt_engine #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_engine (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .q_valid     (q_valid),
        .q_req       (q_req),
        .q_pop       (q_pop),
        .ttl         (ttl_reg),
        .max_entries (max_reg),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data)
    );

endmodule
